// ===== src/three_axis_moving_average_assert.svh =====
// Assertion macros for the three-axis moving average checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, off during reset
`define TAM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tam_pkg.sv =====
// Shared widths, register indexes and types for the three-axis moving average.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tam_pkg;

  localparam int NUM_AXES   = 3;
  localparam int SAMPLE_W   = 16;
  localparam int RANGE_W    = 13;
  localparam int INTERVAL_W = 8;
  localparam int Q_W        = 13;
  localparam int MEAN_W     = 13;
  localparam int SUM_W      = 20;
  // magnitude of a running total, which never reaches 2**19
  localparam int ABS_W      = 19;
  localparam int QUO_W      = MEAN_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam int Q_MAX = 4095;
  localparam int Q_MIN = -4096;

  localparam logic [RANGE_W-1:0]    RANGE_RESET    = 13'd392;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd10;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RANGE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 1'b1;

  // one scaled value per axis, element 0 is x
  typedef logic [NUM_AXES-1:0][Q_W-1:0] tam_triple_t;

endpackage

// ===== src/tam_scale.sv =====
// Maps one raw signed sample onto -r..r-1 and clamps it to the 13-bit range.
// Depends on tam_pkg.
`timescale 1ns / 1ps

module tam_scale import tam_pkg::*; (
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [RANGE_W-1:0]  scale_range,
  output logic signed [Q_W-1:0]      scaled
);

  localparam int PROD_W = SAMPLE_W + RANGE_W + 1;

  logic        [SAMPLE_W-1:0] offset;
  logic        [RANGE_W:0]    span;
  logic        [PROD_W-1:0]   prod;
  logic        [RANGE_W:0]    hi;
  logic signed [RANGE_W+1:0]  diff;

  always_comb begin
    // flip the sign bit: s + 32768 as an unsigned word
    offset = {~sample[SAMPLE_W-1], sample[SAMPLE_W-2:0]};
    span   = {scale_range, 1'b0};
    prod   = PROD_W'(offset) * PROD_W'(span);
    hi     = prod[SAMPLE_W +: RANGE_W+1];
    diff   = $signed({1'b0, hi}) - $signed({2'b00, scale_range});
    if (diff > Q_MAX) begin
      scaled = Q_W'(Q_MAX);
    end else if (diff < Q_MIN) begin
      scaled = Q_W'(Q_MIN);
    end else begin
      scaled = diff[Q_W-1:0];
    end
  end

endmodule

// ===== src/tam_cell.sv =====
// One window cell: holds the scaled x, y, z of one past word and passes it on.
// Depends on tam_pkg.
`timescale 1ns / 1ps

module tam_cell import tam_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  tam_triple_t d,
  output tam_triple_t q
);

  tam_triple_t val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift_en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

// ===== src/three_axis_moving_average.sv =====
// Three-axis boxcar moving average over WINDOW samples with a decimated report flag.
//
// Input channel (in_valid/in_ready) takes one word of three raw 16-bit samples.
// Output channel (out_valid/out_ready) returns one word per input: the three
// window means, truncated toward zero, and the report flag.
// Config port: cfg_we writes cfg_wdata to register cfg_index (0 scale range,
// 1 report interval); write only while no word is in flight.
//
// Four register stages: scale, window update, reciprocal multiply, sign fix. The
// first loads at the input accept edge; the word then moves through window update
// and reciprocal multiply to the sign fix stage, where out_valid rises. Throughput
// is one word per cycle while out_ready is high; the only data loop is the total add.
// The window is a chain of WINDOW cells shifted once per word; the tail cell
// gives the value that leaves the total.
// When the receiver stalls, words collect in the four stages; in_ready stays
// high until all four hold a word. in_ready is always high while out_valid is low.
// Reset (synchronous, active low) zeroes the window, totals and report counter,
// restores the registers to 392 and 10 and empties the pipeline.
// Depends on tam_pkg, tam_scale and tam_cell.
`timescale 1ns / 1ps

module three_axis_moving_average import tam_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_W-1:0]   in_sample_x,
  input  logic signed [SAMPLE_W-1:0]   in_sample_y,
  input  logic signed [SAMPLE_W-1:0]   in_sample_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [MEAN_W-1:0]     out_mean_x,
  output logic signed [MEAN_W-1:0]     out_mean_y,
  output logic signed [MEAN_W-1:0]     out_mean_z,
  output logic                         out_report,
  input  logic                         cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_wdata
);

  // floor(a / WINDOW) == (a * RECIP) >> DIV_SH for every a below 2**ABS_W
  localparam int DIV_SH = ABS_W + $clog2(WINDOW);
  localparam logic [DIV_SH:0] RECIP =
    (DIV_SH+1)'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int PROD_W = ABS_W + DIV_SH + 1;

  logic [RANGE_W-1:0]    scale_range_r;
  logic [INTERVAL_W-1:0] report_interval_r;
  logic [INTERVAL_W-1:0] skip_r;
  logic                  report_nxt;

  logic a_vld_r, b_vld_r, c_vld_r;
  logic a_rep_r, b_rep_r, c_rep_r;
  logic ld_b, ld_c, ld_d;
  logic in_acc;

  logic signed [SAMPLE_W-1:0] samples [NUM_AXES];
  logic signed [Q_W-1:0]      sc_q    [NUM_AXES];
  logic        [MEAN_W-1:0]   d_mean_r [NUM_AXES];

  tam_triple_t a_q_r;
  tam_triple_t chain [WINDOW+1];

  // handshake: a stage loads when the one after it is empty or moving on
  assign ld_d     = c_vld_r & (~out_valid | out_ready);
  assign ld_c     = b_vld_r & (~c_vld_r | ld_d);
  assign ld_b     = a_vld_r & (~b_vld_r | ld_c);
  assign in_ready = ~a_vld_r | ld_b;
  assign in_acc   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_range_r     <= RANGE_RESET;
      report_interval_r <= INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_RANGE:     scale_range_r     <= cfg_wdata[RANGE_W-1:0];
        REG_REPORT_INTERVAL: report_interval_r <= cfg_wdata[INTERVAL_W-1:0];
      endcase
    end
  end

  assign samples[0] = in_sample_x;
  assign samples[1] = in_sample_y;
  assign samples[2] = in_sample_z;

  assign report_nxt = (skip_r >= report_interval_r);

  // stage A: scale and decimation decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= '0;
      a_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        skip_r <= report_nxt ? '0 : skip_r + 1'b1;
      end
      if (in_acc) begin
        a_vld_r <= 1'b1;
      end else if (ld_b) begin
        a_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_q_r   <= {sc_q[2], sc_q[1], sc_q[0]};
      a_rep_r <= report_nxt;
    end
  end

  // window cells advance once per word leaving stage A
  assign chain[0] = a_q_r;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    tam_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ld_b),
      .d        (chain[i]),
      .q        (chain[i+1])
    );
  end

  // stage valids for B (totals), C (quotient) and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld_b) begin
        b_vld_r <= 1'b1;
      end else if (ld_c) begin
        b_vld_r <= 1'b0;
      end
      if (ld_c) begin
        c_vld_r <= 1'b1;
      end else if (ld_d) begin
        c_vld_r <= 1'b0;
      end
      if (ld_d) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      b_rep_r <= a_rep_r;
    end
    if (ld_c) begin
      c_rep_r <= b_rep_r;
    end
    if (ld_d) begin
      out_report <= c_rep_r;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [SUM_W-1:0]  sum_r;
    logic signed [SUM_W-1:0]  sum_nxt;
    logic        [SUM_W-1:0]  sum_neg;
    logic        [ABS_W-1:0]  mag;
    logic        [PROD_W-1:0] prod;
    logic        [QUO_W-1:0]  c_quot_r;
    logic        [QUO_W-1:0]  quot_neg;
    logic                     c_neg_r;

    tam_scale u_scale (
      .sample      (samples[a]),
      .scale_range (scale_range_r),
      .scaled      (sc_q[a])
    );

    // drop the oldest value, add the newest
    always_comb begin
      sum_nxt = sum_r + SUM_W'($signed(a_q_r[a])) - SUM_W'($signed(chain[WINDOW][a]));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sum_r <= '0;
      end else if (ld_b) begin
        sum_r <= sum_nxt;
      end
    end

    always_comb begin
      sum_neg = -sum_r;
      mag     = sum_r[SUM_W-1] ? sum_neg[ABS_W-1:0] : sum_r[ABS_W-1:0];
      prod    = PROD_W'(mag) * PROD_W'(RECIP);
    end

    always_ff @(posedge clk) begin
      if (ld_c) begin
        c_quot_r <= prod[DIV_SH +: QUO_W];
        c_neg_r  <= sum_r[SUM_W-1];
      end
    end

    // restore the sign: truncation toward zero
    assign quot_neg = -c_quot_r;

    always_ff @(posedge clk) begin
      if (ld_d) begin
        d_mean_r[a] <= c_neg_r ? quot_neg[MEAN_W-1:0] : c_quot_r[MEAN_W-1:0];
      end
    end
  end

  assign out_mean_x = d_mean_r[0];
  assign out_mean_y = d_mean_r[1];
  assign out_mean_z = d_mean_r[2];

endmodule

// ===== src/tam_checker.sv =====
// Port-level checks for the three-axis moving average, bound to the top level.
// Depends on tam_pkg and three_axis_moving_average_assert.svh.
`timescale 1ns / 1ps
`include "three_axis_moving_average_assert.svh"

module tam_checker import tam_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [MEAN_W-1:0] out_mean_x,
  input logic signed [MEAN_W-1:0] out_mean_y,
  input logic signed [MEAN_W-1:0] out_mean_z,
  input logic                     out_report
);

  // a stalled result word holds
  `TAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mean_x) && $stable(out_mean_y) && $stable(out_mean_z) && $stable(out_report), "stalled result word changed")

  // with the output register empty, no stage can block the input
  `TAM_ASSERT_IMPL(a_in_ready_free, !out_valid, in_ready, "input blocked while output empty")

  // the first word after reset must pass every stage before out_valid rises
  `TAM_ASSERT_IMPL(a_reset_quiet, $rose(rst_n), !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid, "result appeared too early after reset")

  // input side: a word offered but not taken stays offered
  `TAM_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid, "input valid dropped before accept")

endmodule

bind three_axis_moving_average tam_checker u_tam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_mean_x (out_mean_x),
  .out_mean_y (out_mean_y),
  .out_mean_z (out_mean_z),
  .out_report (out_report)
);
